>>> rtl/aige_pkg.sv
// Shared types, constants and AES helper functions for the AES IGE engine.
// No dependencies; every other file in rtl imports this package.
package aige_pkg;

    localparam int BlockW   = 128;
    localparam int HalfW    = 64;
    localparam int WordW    = 32;
    localparam int RkDepth  = 60;
    localparam int RkRows   = 15;
    localparam int RkAddrW  = 6;
    localparam int RoundW   = 4;
    localparam int PaddrW   = 6;
    localparam int PdataW   = 64;

    localparam logic [2:0] RegKey0   = 3'd0;
    localparam logic [2:0] RegKey1   = 3'd1;
    localparam logic [2:0] RegKey2   = 3'd2;
    localparam logic [2:0] RegKey3   = 3'd3;
    localparam logic [2:0] RegKeyLen = 3'd4;
    localparam logic [2:0] RegDir    = 3'd5;

    localparam logic [1:0] KeyLen128 = 2'd0;
    localparam logic [1:0] KeyLen192 = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_INIT,
        ST_ROUND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic       start;
        logic       encrypt;
        logic [1:0] key_len;
    } ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } sts_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // byte j of the state is bits [127-8j -: 8] (big-endian)
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3, al;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i+4*c] = b[i + 4*((c+i) & 3)];
        for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            al = a0 ^ a1 ^ a2 ^ a3;
            if (!last) begin
                t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [7:0] mul_inv(input logic [7:0] a, input logic [1:0] sel);
        // sel picks the constant: 0 -> 14, 1 -> 11, 2 -> 13, 3 -> 9
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        unique case (sel)
            2'd0: return x8 ^ x4 ^ x2;
            2'd1: return x8 ^ x2 ^ a;
            2'd2: return x8 ^ x4 ^ a;
            default: return x8 ^ a;
        endcase
    endfunction

    // inverse shift + inverse sub bytes; key added by caller, then mix unless last
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [7:0] t [16];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int i = 0; i < 4; i++)
                t[i + 4*((c+i) & 3)] = INV_SBOX[s[127-8*(i+4*c) -: 8]];
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        return o;
    endfunction

    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a [4];
        logic [127:0] o;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) a[j] = s[127-8*(4*c+j) -: 8];
            o[127-8*(4*c)   -: 8] = mul_inv(a[0],2'd0) ^ mul_inv(a[1],2'd1)
                                  ^ mul_inv(a[2],2'd2) ^ mul_inv(a[3],2'd3);
            o[127-8*(4*c+1) -: 8] = mul_inv(a[0],2'd3) ^ mul_inv(a[1],2'd0)
                                  ^ mul_inv(a[2],2'd1) ^ mul_inv(a[3],2'd2);
            o[127-8*(4*c+2) -: 8] = mul_inv(a[0],2'd2) ^ mul_inv(a[1],2'd3)
                                  ^ mul_inv(a[2],2'd0) ^ mul_inv(a[3],2'd1);
            o[127-8*(4*c+3) -: 8] = mul_inv(a[0],2'd1) ^ mul_inv(a[1],2'd2)
                                  ^ mul_inv(a[2],2'd3) ^ mul_inv(a[3],2'd0);
        end
        return o;
    endfunction

endpackage

>>> rtl/aige_keysched.sv
// Key expansion: builds one 32-bit schedule word per cycle into a local memory.
// Depends on aige_pkg (S-box, sub_word, xtime).
module aige_keysched (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            key_len,
    input  logic [255:0]          key,
    input  logic [3:0]            rd_round,
    output logic [127:0]          rd_key,
    output logic                  done
);
    import aige_pkg::*;

    // one row per round key, four schedule words each
    logic [127:0] rk_mem [RkRows];
    logic [127:0] rd_key_reg;
    logic [255:0] win_reg, win_next;     // last nk words, newest at bits [31:0]
    logic [95:0]  grp_reg, grp_next;     // words of the row being built, oldest on top
    logic [RkAddrW-1:0] idx_reg, idx_next;
    logic [3:0]   mod_reg, mod_next;     // i % nk
    logic [7:0]   rcon_reg, rcon_next;
    logic         busy_reg, busy_next;
    logic         done_reg, done_next;
    logic [3:0]   nk;
    logic [RkAddrW-1:0] total;
    logic [31:0]  prev, oldw, t, neww;

    always_comb
    begin
        priority if (key_len == KeyLen128) nk = 4'd4;
        else if (key_len == KeyLen192) nk = 4'd6;
        else nk = 4'd8;
        total = RkAddrW'(4 * (nk + 7));
    end

    always_comb
    begin
        prev = win_reg[31:0];
        oldw = win_reg[32*nk-1 -: 32];
        t = prev;
        if (mod_reg == 4'd0)
            t = sub_word({prev[23:0], prev[31:24]}) ^ {rcon_reg, 24'd0};
        else if (nk == 4'd8 && mod_reg == 4'd4)
            t = sub_word(prev);
        // the first nk words are the raw key, word 0 first
        if (idx_reg < RkAddrW'(nk))
            neww = key[255-32*idx_reg[2:0] -: 32];
        else
            neww = oldw ^ t;
        win_next = win_reg;
        grp_next = grp_reg;
        idx_next = idx_reg;
        mod_next = mod_reg;
        rcon_next = rcon_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            idx_next = '0;
            mod_next = 4'd0;
            rcon_next = 8'h01;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            win_next = {win_reg[223:0], neww};
            grp_next = {grp_reg[63:0], neww};
            idx_next = idx_reg + 1'b1;
            mod_next = (mod_reg == nk - 4'd1) ? 4'd0 : mod_reg + 4'd1;
            if (idx_reg >= RkAddrW'(nk) && mod_reg == 4'd0) rcon_next = xtime(rcon_reg);
            if (idx_reg == total - 1'b1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        grp_reg  <= grp_next;
        idx_reg  <= idx_next;
        mod_reg  <= mod_next;
        rcon_reg <= rcon_next;
    end

    // write a full row with its fourth word
    always_ff @(posedge clk)
    begin
        if (busy_reg && idx_reg[1:0] == 2'd3)
            rk_mem[idx_reg[RkAddrW-1:2]] <= {grp_reg, neww};
        rd_key_reg <= rk_mem[rd_round];
    end

    assign rd_key = rd_key_reg;
    assign done = done_reg;

endmodule

>>> rtl/aige_core.sv
// AES round datapath: one shared round unit iterated under a small sequencer.
// Depends on aige_pkg and aige_keysched.
module aige_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aige_pkg::ctl_t         ctl,
    input  logic [255:0]           key,
    input  logic [127:0]           din,
    output logic [127:0]           dout,
    output aige_pkg::sts_t         sts
);
    import aige_pkg::*;

    state_t       state_reg, state_next;
    logic [127:0] s_reg, s_next;
    logic [127:0] din_reg, din_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [3:0]   nr;
    logic         enc_reg, enc_next;
    logic [1:0]   klen_reg, klen_next;
    logic         ks_done;
    logic [3:0]   rd_round;
    logic [127:0] rkey;
    logic [127:0] dsub;

    always_comb
    begin
        priority if (klen_reg == KeyLen128) nr = 4'd10;
        else if (klen_reg == KeyLen192) nr = 4'd12;
        else nr = 4'd14;
    end

    // key read for the round the sequencer works on next cycle
    assign rd_round = rnd_next;

    aige_keysched u_ks (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.start),
        .key_len  (ctl.key_len),
        .key      (key),
        .rd_round (rd_round),
        .rd_key   (rkey),
        .done     (ks_done)
    );

    assign dsub = dec_sub(s_reg) ^ rkey;

    always_comb
    begin
        state_next = state_reg;
        s_next = s_reg;
        din_next = din_reg;
        rnd_next = rnd_reg;
        enc_next = enc_reg;
        klen_next = klen_reg;
        sts.busy = (state_reg != ST_IDLE);
        sts.done = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (ctl.start)
                begin
                    din_next = din;
                    enc_next = ctl.encrypt;
                    klen_next = ctl.key_len;
                    state_next = ST_KEXP;
                end
                rnd_next = 4'd0;
            end
            ST_KEXP:
            begin
                // hold until the schedule is complete, then fetch the first key
                rnd_next = enc_reg ? 4'd0 : nr;
                if (ks_done) state_next = ST_INIT;
            end
            ST_INIT:
            begin
                s_next = din_reg ^ rkey;
                rnd_next = enc_reg ? 4'd1 : nr - 4'd1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (enc_reg)
                begin
                    s_next = enc_round(s_reg, rnd_reg == nr) ^ rkey;
                    if (rnd_reg == nr) state_next = ST_DONE;
                    else rnd_next = rnd_reg + 4'd1;
                end
                else
                begin
                    if (rnd_reg == 4'd0)
                    begin
                        s_next = dsub;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        s_next = inv_mix(dsub);
                        rnd_next = rnd_reg - 4'd1;
                    end
                end
            end
            ST_DONE:
            begin
                sts.done = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rnd_reg <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        din_reg <= din_next;
        enc_reg <= enc_next;
        klen_reg <= klen_next;
    end

    assign dout = s_reg;

    a_done_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> $past(state_reg) == ST_ROUND)
        else $error("done without a final round");
    a_init_after_kexp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_INIT |-> $past(state_reg) == ST_KEXP)
        else $error("init not preceded by key expansion");
    a_enc_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && enc_reg) |-> (rnd_reg != 4'd0 && rnd_reg <= nr))
        else $error("encrypt round out of range");

endmodule

>>> rtl/aes_ige_mode_engine.sv
// AES-IGE engine top level: APB registers, chaining state, output register.
// Depends on aige_pkg and aige_core.
//
// One block at a time: a load item's result is registered at the edge that
// accepts it. A data item first expands the key one schedule word per cycle,
// key words included, for a 128, 192 or 256-bit key, and then runs one AES
// round per cycle through a shared round unit. The edge that registers its
// result also clears busy, so the next item can then be accepted unless
// out_stall holds that result in the output register.
// The output register frees the input side as soon as a result is taken.
module aes_ige_mode_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [aige_pkg::PaddrW-1:0] paddr,
    input  logic [aige_pkg::PdataW-1:0] pwdata,
    output logic [aige_pkg::PdataW-1:0] prdata,
    output logic                       pready,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       req_type,
    input  logic [63:0]                block_hi,
    input  logic [63:0]                block_lo,
    input  logic [63:0]                iv_cipher_hi,
    input  logic [63:0]                iv_cipher_lo,
    input  logic [63:0]                iv_plain_hi,
    input  logic [63:0]                iv_plain_lo,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [63:0]                result_hi,
    output logic [63:0]                result_lo,
    output logic [63:0]                chain_cipher_hi,
    output logic [63:0]                chain_cipher_lo,
    output logic [63:0]                chain_plain_hi,
    output logic [63:0]                chain_plain_lo
);
    import aige_pkg::*;

    logic [63:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [1:0]   klen_reg;
    logic         dir_reg;
    logic [127:0] pc_reg, pp_reg;
    logic [127:0] blk_reg;
    logic         busy_reg;
    logic         ovalid_reg;
    logic [127:0] res_reg, oc_reg, op_reg;
    logic [2:0]   ridx;
    logic         wr;
    logic         in_acc;
    logic         out_acc;
    ctl_t         ctl;
    sts_t         sts;
    logic [127:0] core_out, core_in, fin;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    assign ridx = paddr[5:3];

    always_comb
    begin
        unique case (ridx)
            RegKey0:   prdata = key0_reg;
            RegKey1:   prdata = key1_reg;
            RegKey2:   prdata = key2_reg;
            RegKey3:   prdata = key3_reg;
            RegKeyLen: prdata = {62'd0, klen_reg};
            RegDir:    prdata = {63'd0, dir_reg};
            default:   prdata = '0;
        endcase
    end

    // out register holds only one result; accept only when it is free or leaving
    assign in_stall = busy_reg | (ovalid_reg & out_stall);
    assign in_acc = in_valid & ~in_stall;
    assign out_acc = ovalid_reg & ~out_stall;
    assign out_valid = ovalid_reg;

    assign core_in = dir_reg ? ({block_hi, block_lo} ^ pc_reg) : ({block_hi, block_lo} ^ pp_reg);
    assign ctl = '{start: in_acc & ~req_type, encrypt: dir_reg, key_len: klen_reg};

    aige_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .key   ({key0_reg, key1_reg, key2_reg, key3_reg}),
        .din   (core_in),
        .dout  (core_out),
        .sts   (sts)
    );

    assign fin = core_out ^ (dir_reg ? pp_reg : pc_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
            klen_reg <= KeyLen128;
            dir_reg <= 1'b1;
            pc_reg <= '0;
            pp_reg <= '0;
            busy_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                unique case (ridx)
                    RegKey0:   key0_reg <= pwdata;
                    RegKey1:   key1_reg <= pwdata;
                    RegKey2:   key2_reg <= pwdata;
                    RegKey3:   key3_reg <= pwdata;
                    RegKeyLen: klen_reg <= pwdata[1:0];
                    RegDir:    dir_reg <= pwdata[0];
                    default:   ;
                endcase
            end
            // a new result wins over the one leaving in the same cycle
            if ((in_acc && req_type) || sts.done)
                ovalid_reg <= 1'b1;
            else if (out_acc)
                ovalid_reg <= 1'b0;
            if (in_acc)
            begin
                if (req_type)
                begin
                    pc_reg <= {iv_cipher_hi, iv_cipher_lo};
                    pp_reg <= {iv_plain_hi, iv_plain_lo};
                end
                else
                    busy_reg <= 1'b1;
            end
            if (sts.done)
            begin
                busy_reg <= 1'b0;
                pc_reg <= dir_reg ? fin : blk_reg;
                pp_reg <= dir_reg ? blk_reg : fin;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            blk_reg <= {block_hi, block_lo};
            res_reg <= '0;
            oc_reg <= {iv_cipher_hi, iv_cipher_lo};
            op_reg <= {iv_plain_hi, iv_plain_lo};
        end
        if (sts.done)
        begin
            res_reg <= fin;
            oc_reg <= dir_reg ? fin : blk_reg;
            op_reg <= dir_reg ? blk_reg : fin;
        end
    end

    assign result_hi = res_reg[127:64];
    assign result_lo = res_reg[63:0];
    assign chain_cipher_hi = oc_reg[127:64];
    assign chain_cipher_lo = oc_reg[63:0];
    assign chain_plain_hi = op_reg[127:64];
    assign chain_plain_lo = op_reg[63:0];

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !in_acc)
        else $error("item accepted while busy");
    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> busy_reg)
        else $error("core finished with no item");
    a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done |-> !ovalid_reg)
        else $error("result overwrote pending result");

endmodule
